// ===== src/iir_direct_form_filter_core_macros.svh =====
// Assertion helpers for the IIR filter core.
`ifndef IIR_DIRECT_FORM_FILTER_CORE_MACROS_SVH
`define IIR_DIRECT_FORM_FILTER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check outside reset only.
`define IIRDF_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("iirdf assertion failed");
// Check on every edge, reset included.
`define IIRDF_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("iirdf reset assertion failed");
`else
`define IIRDF_ASSERT(label, prop)
`define IIRDF_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ===== src/iirdf_pkg.sv =====
package iirdf_pkg;

  localparam int MAX_ORDER = 3;
  localparam int NUM_TAPS  = 4;
  localparam int SAMPLE_W  = 24;
  localparam int COEF_W    = 32;
  localparam int ORDER_W   = 2;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  localparam int ACC_W     = PROD_W + 3;
  localparam int FRAC_SH   = 24;
  localparam int STEP_W    = $clog2(2 * MAX_ORDER + 1);
  localparam int HIST_AW   = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int CFG_AW    = 3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic [ORDER_W-1:0]         order_t;
  typedef logic [STEP_W-1:0]          step_t;
  typedef logic [CFG_AW-1:0]          cfg_addr_t;

  // Register indexes of the configuration port.
  localparam cfg_addr_t REG_ORDER = 3'd0;
  localparam cfg_addr_t REG_FF0   = 3'd1;
  localparam cfg_addr_t REG_FF1   = 3'd2;
  localparam cfg_addr_t REG_FF2   = 3'd3;
  localparam cfg_addr_t REG_FF3   = 3'd4;
  localparam cfg_addr_t REG_FB1   = 3'd5;
  localparam cfg_addr_t REG_FB2   = 3'd6;
  localparam cfg_addr_t REG_FB3   = 3'd7;

  localparam coef_t COEF_ONE = 32'sh0100_0000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } seq_state_t;

  // Control word from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic issue;
    logic first;
    logic sub;
  } mac_ctl_t;

endpackage

// ===== src/iirdf_mac.sv =====
module iirdf_mac (
  input  logic               clk,
  input  logic               rst_n,
  input  iirdf_pkg::mac_ctl_t ctl,
  input  iirdf_pkg::coef_t   coef_i,
  input  iirdf_pkg::sample_t samp_i,
  output iirdf_pkg::sample_t y_o,
  output logic               clip_o
);
  import iirdf_pkg::*;

  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic                     prod_vld_r;
  logic                     prod_first_r;
  logic                     prod_sub_r;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  acc_base;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [ACC_W-FRAC_SH-1:0] y_wide;
  logic                     fits;

  assign prod_nxt = coef_i * samp_i;
  assign prod_ext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
  assign acc_base = prod_first_r ? '0 : acc_r;

  always_comb begin
    acc_nxt = acc_r;
    if (prod_vld_r) begin
      acc_nxt = prod_sub_r ? (acc_base - prod_ext) : (acc_base + prod_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= ctl.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      prod_r       <= prod_nxt;
      prod_first_r <= ctl.first;
      prod_sub_r   <= ctl.sub;
    end
    acc_r <= acc_nxt;
  end

  // Round half up, then floor by the fraction shift.
  assign rnd    = acc_r + (ACC_W'(1) <<< (FRAC_SH - 1));
  assign y_wide = rnd[ACC_W-1:FRAC_SH];
  assign fits   = (y_wide[ACC_W-FRAC_SH-1:SAMPLE_W-1] == '0) ||
                  (y_wide[ACC_W-FRAC_SH-1:SAMPLE_W-1] == '1);

  always_comb begin
    clip_o = !fits;
    if (fits) begin
      y_o = y_wide[SAMPLE_W-1:0];
    end else if (y_wide[ACC_W-FRAC_SH-1]) begin
      y_o = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      y_o = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

endmodule

// ===== src/iirdf_seq.sv =====
module iirdf_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start_i,
  input  logic                 out_free_i,
  input  iirdf_pkg::order_t    ord_i,
  output logic                 idle_o,
  output iirdf_pkg::step_t     step_o,
  output iirdf_pkg::mac_ctl_t  ctl_o,
  output logic                 fin_o
);
  import iirdf_pkg::*;

  seq_state_t state_r, state_nxt;
  step_t      step_r, step_nxt;
  step_t      last_step;

  assign last_step = STEP_W'(2 * int'(ord_i));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (start_i) state_nxt = ST_RUN;
      ST_RUN:   if (step_r == last_step) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_DONE;
      ST_DONE:  if (out_free_i) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    idle_o    = 1'b0;
    ctl_o     = '0;
    fin_o     = 1'b0;
    step_nxt  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        idle_o   = 1'b1;
        step_nxt = '0;
      end
      ST_RUN: begin
        ctl_o.issue = 1'b1;
        ctl_o.first = (step_r == '0);
        // even nonzero steps are feedback taps
        ctl_o.sub   = (step_r != '0) && !step_r[0];
        step_nxt    = step_r + 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_DONE: begin
        fin_o = out_free_i;
      end
      default: begin
      end
    endcase
  end

  assign step_o = step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

// ===== src/iir_direct_form_filter_core.sv =====
// Direct form I IIR filter, order 0 to 3, on Q1.23 samples with Q8.24
// coefficients. One word in gives one word out: the accumulator is rounded
// half up and saturated to 24 bits, and out_tuser flags a saturated word.
// A single 32x24 multiplier with an accumulator does every tap, one product
// per cycle, and a new word is accepted only once the last one is finished;
// a finished word waits in the output register while the next one is
// computed, and the core stalls only if that register is still full at the
// end. Configuration writes take effect at once and must be made while the
// core is idle.
`include "iir_direct_form_filter_core_macros.svh"

module iir_direct_form_filter_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [23:0]                in_tdata,   // [23:0] sample_in
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [23:0]                out_tdata,  // [23:0] sample_out
  output logic                       out_tuser,  // [0] clipped
  input  logic                       cfg_we,
  input  iirdf_pkg::cfg_addr_t       cfg_addr,
  input  logic [31:0]                cfg_wdata
);
  import iirdf_pkg::*;

  order_t   order_r;
  coef_t    ff_coef_r [0:NUM_TAPS-1];
  coef_t    fb_coef_r [1:NUM_TAPS-1];
  sample_t  x_hist_r  [0:MAX_ORDER-1];
  sample_t  y_hist_r  [0:MAX_ORDER-1];
  sample_t  x_r;
  sample_t  out_sample_r;
  logic     out_clip_r;
  logic     out_valid_r;

  order_t   ord_eff;
  logic     start;
  logic     out_free;
  logic     seq_idle;
  logic     seq_fin;
  step_t    step;
  mac_ctl_t mac_ctl;
  order_t   tap;
  logic [HIST_AW-1:0] hidx;
  coef_t    mac_coef;
  sample_t  mac_samp;
  sample_t  mac_y;
  logic     mac_clip;

  assign ord_eff  = (order_r > order_t'(MAX_ORDER)) ? order_t'(MAX_ORDER) : order_r;
  assign start    = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  // Hold off the input while reset is applied.
  assign in_tready = rst_n && seq_idle;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= '0;
      for (int i = 0; i < NUM_TAPS; i++) begin
        ff_coef_r[i] <= '0;
      end
      for (int i = 1; i < NUM_TAPS; i++) begin
        fb_coef_r[i] <= '0;
      end
      ff_coef_r[0] <= COEF_ONE;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ORDER: order_r      <= cfg_wdata[ORDER_W-1:0];
        REG_FF0:   ff_coef_r[0] <= cfg_wdata;
        REG_FF1:   ff_coef_r[1] <= cfg_wdata;
        REG_FF2:   ff_coef_r[2] <= cfg_wdata;
        REG_FF3:   ff_coef_r[3] <= cfg_wdata;
        REG_FB1:   fb_coef_r[1] <= cfg_wdata;
        REG_FB2:   fb_coef_r[2] <= cfg_wdata;
        REG_FB3:   fb_coef_r[3] <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  iirdf_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (start),
    .out_free_i (out_free),
    .ord_i      (ord_eff),
    .idle_o     (seq_idle),
    .step_o     (step),
    .ctl_o      (mac_ctl),
    .fin_o      (seq_fin)
  );

  // Step 0 is b0*x; odd steps feedforward taps, even steps feedback taps.
  assign tap  = ORDER_W'((int'(step) + 1) >> 1);
  assign hidx = HIST_AW'(int'(tap) - 1);

  always_comb begin
    if (step == '0) begin
      mac_coef = ff_coef_r[0];
      mac_samp = x_r;
    end else if (step[0]) begin
      mac_coef = ff_coef_r[tap];
      mac_samp = x_hist_r[hidx];
    end else begin
      mac_coef = fb_coef_r[tap];
      mac_samp = y_hist_r[hidx];
    end
  end

  iirdf_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mac_ctl),
    .coef_i (mac_coef),
    .samp_i (mac_samp),
    .y_o    (mac_y),
    .clip_o (mac_clip)
  );

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= in_tdata;
    end
  end

  // Histories shift on every finished word, whatever the order.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_ORDER; i++) begin
        x_hist_r[i] <= '0;
        y_hist_r[i] <= '0;
      end
    end else if (seq_fin) begin
      for (int i = MAX_ORDER - 1; i > 0; i--) begin
        x_hist_r[i] <= x_hist_r[i-1];
        y_hist_r[i] <= y_hist_r[i-1];
      end
      x_hist_r[0] <= x_r;
      y_hist_r[0] <= mac_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (seq_fin) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_fin) begin
      out_sample_r <= mac_y;
      out_clip_r   <= mac_clip;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sample_r;
  assign out_tuser  = out_clip_r;

  `IIRDF_ASSERT(a_busy_after_accept, start |=> !in_tready)
  `IIRDF_ASSERT(a_fin_loads_output, seq_fin |=> out_tvalid)
  `IIRDF_ASSERT(a_issue_only_busy, mac_ctl.issue |-> !in_tready)
  `IIRDF_ASSERT(a_clip_is_rail, (out_tvalid && out_tuser) |-> (out_tdata == 24'h7fffff || out_tdata == 24'h800000))
  `IIRDF_ASSERT_ALWAYS(a_reset_empties_output, !rst_n |=> !out_tvalid)

endmodule
